>>> rtl/core/tlb_page_table_translate_defines.svh
// assertion macros for the tlb translator
// expects clk and arst_n in the scope of each use
`ifndef TLB_PAGE_TABLE_TRANSLATE_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATE_DEFINES_SVH

// same-cycle implication
`define TLBPT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TLBPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/tlbpt_pkg.sv
// shared widths, defaults and controller/datapath handshake types
// no dependencies
package tlbpt_pkg;
	localparam int VA_W = 16;
	localparam int PAGE_W = 8;
	localparam int OFFSET_W = 8;
	localparam int FRAME_W = 8;
	localparam int CNT_W = 32;
	localparam int STAMP_W = 32;
	localparam int PAGE_COUNT = 1 << PAGE_W;
	localparam int TLB_ENTRIES_DEF = 16;

	typedef struct packed {
		logic load;
		logic lookup;
		logic scan;
		logic fill;
		logic emit;
	} tlbpt_cmd_t;

	typedef struct packed {
		logic hit;
		logic free_avail;
		logic scan_last;
		logic out_free;
	} tlbpt_sts_t;
endpackage

>>> rtl/core/tlbpt_req_if.sv
// request channel: one virtual address word
// depends on tlbpt_pkg
interface tlbpt_req_if import tlbpt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VA_W-1:0]     virtual_address;

	modport source(output valid, output virtual_address, input ready);
	modport sink(input valid, input virtual_address, output ready);
endinterface

>>> rtl/core/tlbpt_rsp_if.sv
// response channel: one translation result word
// depends on tlbpt_pkg
interface tlbpt_rsp_if import tlbpt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VA_W-1:0]     physical_address;
	logic [FRAME_W-1:0]  phys_frame;
	logic                tlb_hit;
	logic                page_fault;
	logic [CNT_W-1:0]    hit_count;
	logic [CNT_W-1:0]    fault_count;

	modport source(output valid, output physical_address, output phys_frame,
		output tlb_hit, output page_fault, output hit_count, output fault_count,
		input ready);
	modport sink(input valid, input physical_address, input phys_frame,
		input tlb_hit, input page_fault, input hit_count, input fault_count,
		output ready);
endinterface

>>> rtl/core/tlb_page_table_translate.sv
// result word registered in the emit state after lookup on a tlb hit or a fill
// into a free entry, or after the lru scan and fill states when an lru victim
// must be found; emit waits while the result register is full and unread; the lru
// scan reads one stamp per cycle; a new word is taken in idle or as a result is emitted
// reset: tlb and page-table valid bits, frame allocator, tick and counters cleared at once
module tlb_page_table_translate import tlbpt_pkg::*; #(
	parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	tlbpt_req_if.sink   req,
	tlbpt_rsp_if.source rsp
);
	tlbpt_cmd_t cmd;
	tlbpt_sts_t sts;

	tlbpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	tlbpt_dpath #(
		.TLB_ENTRIES (TLB_ENTRIES)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.virtual_address  (req.virtual_address),
		.out_ready        (rsp.ready),
		.out_valid        (rsp.valid),
		.physical_address (rsp.physical_address),
		.phys_frame       (rsp.phys_frame),
		.tlb_hit          (rsp.tlb_hit),
		.page_fault       (rsp.page_fault),
		.hit_count        (rsp.hit_count),
		.fault_count      (rsp.fault_count)
	);
endmodule

>>> rtl/core/tlbpt_ctrl.sv
// translation sequencer: lookup, lru scan, fill and result hand-off
// depends on tlbpt_pkg and the assertion macro header
`include "tlb_page_table_translate_defines.svh"

module tlbpt_ctrl import tlbpt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output tlbpt_cmd_t cmd,
	input  tlbpt_sts_t sts
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOOK = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_FILL = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.lookup = 1'b1;
				if (sts.hit || sts.free_avail) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					in_ready = 1'b1;
					if (in_valid) begin
						cmd.load = 1'b1;
						state_d = ST_LOOK;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`TLBPT_ASSERT_NEXT(a_load_then_lookup, cmd.load, cmd.lookup, "load not followed by lookup")
endmodule

>>> rtl/core/tlbpt_dpath.sv
// tlb entries, page table, lru scan, counters and result register
// depends on tlbpt_pkg and the assertion macro header
`include "tlb_page_table_translate_defines.svh"

module tlbpt_dpath import tlbpt_pkg::*; #(
	parameter int TLB_ENTRIES = TLB_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tlbpt_cmd_t          cmd,
	output tlbpt_sts_t          sts,
	input  logic [VA_W-1:0]     virtual_address,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [VA_W-1:0]     physical_address,
	output logic [FRAME_W-1:0]  phys_frame,
	output logic                tlb_hit,
	output logic                page_fault,
	output logic [CNT_W-1:0]    hit_count,
	output logic [CNT_W-1:0]    fault_count
);
	localparam int IDX_W = $clog2(TLB_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

	logic [PAGE_W-1:0]   page_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [FRAME_W-1:0]  map_rd_q;
	logic [FRAME_W-1:0]  map_mem [PAGE_COUNT];
	logic [PAGE_COUNT-1:0] map_valid_q;
	logic [FRAME_W-1:0]  next_frame_q;

	logic [TLB_ENTRIES-1:0] tlb_valid_q;
	logic [PAGE_W-1:0]   tlb_page_q [TLB_ENTRIES];
	logic [FRAME_W-1:0]  tlb_frame_q [TLB_ENTRIES];
	logic [STAMP_W-1:0]  tlb_stamp_q [TLB_ENTRIES];

	logic [STAMP_W-1:0]  tick_q;
	logic [CNT_W-1:0]    hits_q;
	logic [CNT_W-1:0]    faults_q;
	logic [FRAME_W-1:0]  frame_q;
	logic                hit_q;
	logic                fault_q;
	logic [IDX_W-1:0]    scan_idx_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [STAMP_W-1:0]  best_stamp_q;
	logic                out_valid_q;

	logic [TLB_ENTRIES-1:0] hit_vec;
	logic [IDX_W-1:0]    hit_idx;
	logic [IDX_W-1:0]    free_idx;
	logic                map_hit;
	logic [FRAME_W-1:0]  miss_frame;
	logic [STAMP_W-1:0]  cur_stamp;
	logic                miss_fault;

	always_comb begin
		hit_idx = '0;
		free_idx = '0;
		for (int k = 0; k < TLB_ENTRIES; k++) begin
			hit_vec[k] = tlb_valid_q[k] && (tlb_page_q[k] == page_q);
			if (hit_vec[k]) begin
				hit_idx = hit_idx | IDX_W'(k);
			end
		end
		for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
			if (!tlb_valid_q[k]) begin
				free_idx = IDX_W'(k);
			end
		end
	end

	assign map_hit = map_valid_q[page_q];
	assign miss_frame = map_hit ? map_rd_q : next_frame_q;
	assign miss_fault = cmd.lookup && !sts.hit && !map_hit;
	assign cur_stamp = tlb_stamp_q[scan_idx_q];

	assign sts.hit = |hit_vec;
	assign sts.free_avail = ~&tlb_valid_q;
	assign sts.scan_last = (scan_idx_q == LAST_IDX);
	assign sts.out_free = !out_valid_q || out_ready;

	// page table frames
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			map_rd_q <= map_mem[virtual_address[VA_W-1:OFFSET_W]];
		end
		if (miss_fault) begin
			map_mem[page_q] <= next_frame_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= virtual_address[VA_W-1:OFFSET_W];
			offset_q <= virtual_address[OFFSET_W-1:0];
		end
		if (cmd.lookup) begin
			if (sts.hit) begin
				frame_q <= tlb_frame_q[hit_idx];
				tlb_stamp_q[hit_idx] <= tick_q;
				hit_q <= 1'b1;
				fault_q <= 1'b0;
			end else begin
				frame_q <= miss_frame;
				hit_q <= 1'b0;
				fault_q <= !map_hit;
				if (sts.free_avail) begin
					tlb_page_q[free_idx] <= page_q;
					tlb_frame_q[free_idx] <= miss_frame;
					tlb_stamp_q[free_idx] <= tick_q;
				end else begin
					scan_idx_q <= IDX_W'(1);
					best_idx_q <= '0;
					best_stamp_q <= tlb_stamp_q[0];
				end
			end
		end
		if (cmd.scan) begin
			scan_idx_q <= scan_idx_q + IDX_W'(1);
			if (cur_stamp < best_stamp_q) begin
				best_idx_q <= scan_idx_q;
				best_stamp_q <= cur_stamp;
			end
		end
		if (cmd.fill) begin
			tlb_page_q[best_idx_q] <= page_q;
			tlb_frame_q[best_idx_q] <= frame_q;
			tlb_stamp_q[best_idx_q] <= tick_q;
		end
		if (cmd.emit) begin
			physical_address <= {frame_q, offset_q};
			phys_frame <= frame_q;
			tlb_hit <= hit_q;
			page_fault <= fault_q;
			hit_count <= hits_q;
			fault_count <= faults_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tlb_valid_q <= '0;
			map_valid_q <= '0;
			next_frame_q <= '0;
			tick_q <= '0;
			hits_q <= '0;
			faults_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.lookup && sts.hit && hits_q != '1) begin
				hits_q <= hits_q + CNT_W'(1);
			end
			if (cmd.lookup && !sts.hit && sts.free_avail) begin
				tlb_valid_q[free_idx] <= 1'b1;
			end
			if (miss_fault) begin
				map_valid_q[page_q] <= 1'b1;
				next_frame_q <= next_frame_q + FRAME_W'(1);
				if (faults_q != '1) begin
					faults_q <= faults_q + CNT_W'(1);
				end
			end
			if (cmd.emit) begin
				tick_q <= tick_q + STAMP_W'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`TLBPT_ASSERT_IMPL(a_single_match, cmd.lookup, $onehot0(hit_vec), "tlb holds a page twice")
	`TLBPT_ASSERT_IMPL(a_scan_when_full, cmd.scan, &tlb_valid_q, "lru scan with a free entry")
	`TLBPT_ASSERT_NEXT(a_hits_monotonic, 1'b1, hits_q >= $past(hits_q), "hit count went down")
	`TLBPT_ASSERT_IMPL(a_hit_no_fault, cmd.emit, !(hit_q && fault_q), "hit and fault together")
endmodule
